// ===== rtl/rlsc_pkg.sv =====
`default_nettype none

package rlsc_pkg;

  localparam int MODE_W = 3;
  localparam int WORD_W = 32;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [WORD_W-1:0] word_t;

  // request modes
  localparam mode_t MODE_PUSH   = 3'd0;
  localparam mode_t MODE_POP    = 3'd1;
  localparam mode_t MODE_TOP    = 3'd2;
  localparam mode_t MODE_SIZE   = 3'd3;
  localparam mode_t MODE_FINISH = 3'd4;

  // result kinds
  localparam mode_t KIND_TOP   = 3'd0;
  localparam mode_t KIND_SIZE  = 3'd1;
  localparam mode_t KIND_FULL  = 3'd2;
  localparam mode_t KIND_EMPTY = 3'd3;
  localparam mode_t KIND_SAFE  = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/rlsc_if.sv =====
`default_nettype none

interface rlsc_in_if;
  import rlsc_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  word_t count;
  word_t value;
  modport source (output valid, output mode, output count, output value, input ready);
  modport sink   (input valid, input mode, input count, input value, output ready);
endinterface

interface rlsc_out_if;
  import rlsc_pkg::*;
  logic  valid;
  logic  ready;
  mode_t kind;
  word_t data;
  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface

interface rlsc_cfg_if;
  import rlsc_pkg::*;
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rlsc_store.sv =====
`default_nettype none

module rlsc_store #(
  parameter int DEPTH = 1024,
  parameter int CW    = 32,
  parameter int AW    = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_cnt_en,
  input  wire logic              wr_val_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [CW-1:0]     wr_cnt,
  input  wire rlsc_pkg::word_t   wr_val,
  input  wire logic [AW-1:0]     rd_addr,
  output logic [CW-1:0]          rd_cnt,
  output rlsc_pkg::word_t        rd_val
);
  import rlsc_pkg::*;

  logic [CW-1:0] cnt_mem [DEPTH];
  word_t         val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_cnt_en) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt <= cnt_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/rlsc_ctrl.sv =====
`default_nettype none

module rlsc_ctrl #(
  parameter int DEPTH = 1024,
  parameter int CW    = 32,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  rlsc_in_if.sink              in_s,
  rlsc_out_if.source           out_m,
  rlsc_cfg_if.sink             cfg_s,
  output logic                 wr_cnt_en,
  output logic                 wr_val_en,
  output logic [AW-1:0]        wr_addr,
  output logic [CW-1:0]        wr_cnt,
  output rlsc_pkg::word_t      wr_val,
  output logic [AW-1:0]        rd_addr,
  input  wire logic [CW-1:0]   rd_cnt,
  input  wire rlsc_pkg::word_t rd_val
);
  import rlsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_TOP  = 2'd2;

  localparam logic [AW:0] PTR_FULL = (AW+1)'(DEPTH);

  logic [1:0]    state_r, state_nxt;
  logic [AW:0]   ptr_r, ptr_nxt;
  word_t         total_r, total_nxt;
  logic          failed_r, failed_nxt;
  word_t         cap_r;
  logic [CW-1:0] left_r, left_nxt;
  logic          ov_r, ov_nxt;
  mode_t         okind_r, okind_nxt;
  word_t         odata_r, odata_nxt;

  logic          acc;
  logic [CW-1:0] cnt;
  logic [WORD_W:0] sum;
  logic [AW:0]   ptr_m1;
  logic [AW:0]   ptr_m2;
  logic [CW-1:0] left_sub;

  assign in_s.ready  = (state_r == ST_IDLE) && (!ov_r || out_m.ready);
  assign acc         = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;
  assign out_m.valid = ov_r;
  assign out_m.kind  = okind_r;
  assign out_m.data  = odata_r;

  assign cnt      = in_s.count[CW-1:0];
  assign sum      = {1'b0, total_r} + (WORD_W+1)'(cnt);
  assign ptr_m1   = ptr_r - (AW+1)'(1);
  assign ptr_m2   = ptr_r - (AW+1)'(2);
  assign left_sub = left_r - rd_cnt;

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    total_nxt  = total_r;
    failed_nxt = failed_r;
    left_nxt   = left_r;
    ov_nxt     = ov_r && !out_m.ready;
    okind_nxt  = okind_r;
    odata_nxt  = odata_r;
    wr_cnt_en  = 1'b0;
    wr_val_en  = 1'b0;
    wr_addr    = ptr_r[AW-1:0];
    wr_cnt     = cnt;
    wr_val     = in_s.value;
    rd_addr    = ptr_m1[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_s.mode)
            MODE_FINISH: begin
              ptr_nxt    = '0;
              total_nxt  = '0;
              failed_nxt = 1'b0;
              if (!failed_r) begin
                ov_nxt    = 1'b1;
                okind_nxt = KIND_SAFE;
                odata_nxt = '0;
              end
            end
            MODE_PUSH: begin
              if (!failed_r && cnt != '0) begin
                if (sum > {1'b0, cap_r} || ptr_r == PTR_FULL) begin
                  failed_nxt = 1'b1;
                  ov_nxt     = 1'b1;
                  okind_nxt  = KIND_FULL;
                  odata_nxt  = '0;
                end else begin
                  wr_cnt_en = 1'b1;
                  wr_val_en = 1'b1;
                  ptr_nxt   = ptr_r + (AW+1)'(1);
                  total_nxt = sum[WORD_W-1:0];
                end
              end
            end
            MODE_POP: begin
              if (!failed_r && cnt != '0) begin
                if (WORD_W'(cnt) > total_r) begin
                  failed_nxt = 1'b1;
                  ov_nxt     = 1'b1;
                  okind_nxt  = KIND_EMPTY;
                  odata_nxt  = '0;
                end else begin
                  // top run is read this cycle, walk starts next
                  total_nxt = total_r - WORD_W'(cnt);
                  left_nxt  = cnt;
                  state_nxt = ST_POP;
                end
              end
            end
            MODE_TOP: begin
              if (!failed_r) begin
                if (total_r == '0 || ptr_r == '0) begin
                  failed_nxt = 1'b1;
                  ov_nxt     = 1'b1;
                  okind_nxt  = KIND_EMPTY;
                  odata_nxt  = '0;
                end else begin
                  state_nxt = ST_TOP;
                end
              end
            end
            MODE_SIZE: begin
              if (!failed_r) begin
                ov_nxt    = 1'b1;
                okind_nxt = KIND_SIZE;
                odata_nxt = total_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (left_r < rd_cnt) begin
          // shrink the top run and stop
          wr_cnt_en = 1'b1;
          wr_addr   = ptr_m1[AW-1:0];
          wr_cnt    = rd_cnt - left_r;
          left_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          // drop the whole run, fetch the one below
          left_nxt = left_sub;
          ptr_nxt  = ptr_m1;
          rd_addr  = ptr_m2[AW-1:0];
          if (left_sub == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TOP: begin
        ov_nxt    = 1'b1;
        okind_nxt = KIND_TOP;
        odata_nxt = rd_val;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ptr_r    <= '0;
      total_r  <= '0;
      failed_r <= 1'b0;
      cap_r    <= '0;
      left_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      total_r  <= total_nxt;
      failed_r <= failed_nxt;
      left_r   <= left_nxt;
      ov_r     <= ov_nxt;
      if (cfg_s.valid) begin
        cap_r <= cfg_s.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    odata_r <= odata_nxt;
  end

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_FULL)
    else $error("run pointer beyond store depth");

  a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> (left_r != '0 && ptr_r != '0))
    else $error("pop walk with nothing left or no runs");

  a_total_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> ((total_r == '0) == (ptr_r == '0)))
    else $error("element total disagrees with run pointer");

  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && failed_r && in_s.mode != MODE_FINISH) |=> (!ov_r && state_r == ST_IDLE))
    else $error("result after error before finish");
`endif

endmodule

`default_nettype wire

// ===== rtl/run_length_stack_with_capacity.sv =====
`default_nettype none

// Channel  Dir  Payload                       Handshake
// in_s     in   mode[2:0] count[31:0] value   valid/ready
// out_m    out  kind[2:0] data[31:0]          valid/ready
// cfg_s    in   data[31:0] (capacity)         valid/ready, ready always high
//
// Push, size, finish and errors are handled in the idle state; top then waits
// for one memory read. Pop walks down the runs it reaches: the walk reads one
// run count from the run store per cycle through its single read port.
// Reset clears pointer, total, error flag and capacity; run store needs no clear.
// A result waits in the output register; the next request is taken as it drains.
module run_length_stack_with_capacity #(
  parameter int RUN_DEPTH   = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rlsc_in_if.sink   in_s,
  rlsc_out_if.source out_m,
  rlsc_cfg_if.sink  cfg_s
);
  import rlsc_pkg::*;

  localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = (COUNT_WIDTH < WORD_W) ? COUNT_WIDTH : WORD_W;

  logic          wr_cnt_en;
  logic          wr_val_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_cnt;
  word_t         wr_val;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_cnt;
  word_t         rd_val;

  rlsc_ctrl #(
    .DEPTH (RUN_DEPTH),
    .CW    (CW),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .out_m     (out_m),
    .cfg_s     (cfg_s),
    .wr_cnt_en (wr_cnt_en),
    .wr_val_en (wr_val_en),
    .wr_addr   (wr_addr),
    .wr_cnt    (wr_cnt),
    .wr_val    (wr_val),
    .rd_addr   (rd_addr),
    .rd_cnt    (rd_cnt),
    .rd_val    (rd_val)
  );

  rlsc_store #(
    .DEPTH (RUN_DEPTH),
    .CW    (CW),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_cnt_en (wr_cnt_en),
    .wr_val_en (wr_val_en),
    .wr_addr   (wr_addr),
    .wr_cnt    (wr_cnt),
    .wr_val    (wr_val),
    .rd_addr   (rd_addr),
    .rd_cnt    (rd_cnt),
    .rd_val    (rd_val)
  );

endmodule

`default_nettype wire
